FILE: design/scdb_pkg.sv
// Shared types and constants for the stack channel DMA buffer.
// Transaction payload structs, request codes and memory command group.
// No dependencies.
package scdb_pkg;

    localparam int STACK_DEPTH_DEF = 1024;

    localparam logic [2:0] REQ_PUSH     = 3'd0;
    localparam logic [2:0] REQ_POP      = 3'd1;
    localparam logic [2:0] REQ_LOAD_PTR = 3'd2;
    localparam logic [2:0] REQ_LOAD_CNT = 3'd3;
    localparam logic [2:0] REQ_XFER     = 3'd4;
    localparam logic [2:0] REQ_TICK     = 3'd5;

    localparam logic [2:0] ADDR_CHANNEL_MODE = 3'd0;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  data_byte;
        logic [9:0]  pointer_value;
        logic [15:0] count_value;
        logic        to_stack;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [9:0]  pointer_now;
        logic        transfer_allowed_out;
        logic        end_of_transfer_out;
        logic [16:0] count_left;
    } rsp_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_cmd_t;

endpackage

FILE: design/scdb_stack_mem.sv
// Byte stack memory: single port, synchronous read with registered read data.
// Clears itself after reset with a sweep of one entry per cycle.
// Depends on scdb_pkg.
module scdb_stack_mem #(
    parameter int STACK_DEPTH = scdb_pkg::STACK_DEPTH_DEF,
    parameter int PTR_W       = $clog2(STACK_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scdb_pkg::mem_cmd_t  cmd,
    input  logic [PTR_W-1:0]    addr,
    input  logic [7:0]          wdata,
    output logic [7:0]          rdata,
    output logic                busy
);
    import scdb_pkg::*;

    logic [7:0]       mem [STACK_DEPTH];
    logic [7:0]       rdata_reg;
    logic             clearing_reg;
    logic [PTR_W-1:0] clr_addr_reg;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;

    assign wr_en   = clearing_reg || cmd.wr;
    assign wr_addr = clearing_reg ? clr_addr_reg : addr;
    assign wr_data = clearing_reg ? 8'd0 : wdata;
    assign rdata   = rdata_reg;
    assign busy    = clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == PTR_W'(STACK_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd && !clearing_reg)
        begin
            rdata_reg <= mem[addr];
        end
    end

endmodule

FILE: design/stack_channel_dma_buffer_core.sv
// Top level of the stack channel DMA buffer: request decode, pointer, count and flags,
// result pipeline and APB register. Depends on scdb_pkg and scdb_stack_mem.
//
// The block takes one request per clock cycle while req_stall is low and returns one
// result transaction per request, in order: the s1 stage register holds each result
// during the synchronous read of the byte memory, then the output register presents it.
// Pointer, count and flags are updated at acceptance, so requests follow back to back
// with no interlock. After reset the memory is zeroed by a sweep of all STACK_DEPTH
// entries, during which req_stall stays high; register writes are taken at any time.
module stack_channel_dma_buffer_core #(
    parameter int STACK_DEPTH = scdb_pkg::STACK_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  scdb_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output scdb_pkg::rsp_t  rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import scdb_pkg::*;

    localparam int PTR_W = $clog2(STACK_DEPTH);

    logic             channel_mode_reg;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [16:0]      count_reg, count_next;
    logic             allowed_reg, allowed_next;
    logic             end_reg, end_next;
    logic             s1_valid_reg;
    logic             s1_pop_reg, s1_pop_next;
    rsp_t             s1_res_reg, s1_res_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg, rsp_next;

    logic             accept;
    logic             s1_adv;
    logic             mem_busy;
    mem_cmd_t         mem_cmd;
    logic [PTR_W-1:0] mem_addr;
    logic [7:0]       mem_rdata;
    logic [9:0]       ptr_red;
    logic [PTR_W-1:0] ptr_inc;
    logic [PTR_W-1:0] ptr_dec;
    logic [16:0]      count_dec;

    scdb_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .PTR_W       (PTR_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (req.data_byte),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_CHANNEL_MODE) ? {31'd0, channel_mode_reg} : 32'd0;
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = mem_busy || (s1_valid_reg && !s1_adv);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ptr_inc   = (ptr_reg == PTR_W'(STACK_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
    assign ptr_dec   = (ptr_reg == '0) ? PTR_W'(STACK_DEPTH - 1) : ptr_reg - PTR_W'(1);
    assign count_dec = count_reg - 17'd1;

    // reduce the loaded pointer modulo the depth
    always_comb
    begin
        ptr_red = req.pointer_value;
        for (int k = 9; k >= 0; k--)
        begin
            if ((STACK_DEPTH << k) < 1024)
            begin
                if (32'(ptr_red) >= (STACK_DEPTH << k))
                begin
                    ptr_red = ptr_red - 10'(STACK_DEPTH << k);
                end
            end
        end
    end

    always_comb
    begin
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        allowed_next = allowed_reg;
        end_next     = end_reg;
        mem_cmd      = '0;
        mem_addr     = ptr_reg;
        s1_pop_next  = 1'b0;
        case (req.req_type)
            REQ_PUSH:
            begin
                count_next   = '0;
                allowed_next = 1'b0;
                ptr_next     = ptr_inc;
                mem_cmd.wr   = accept;
            end
            REQ_POP:
            begin
                count_next   = '0;
                allowed_next = 1'b0;
                ptr_next     = ptr_dec;
                mem_addr     = ptr_dec;
                mem_cmd.rd   = accept;
                s1_pop_next  = 1'b1;
            end
            REQ_LOAD_PTR:
            begin
                count_next   = '0;
                allowed_next = 1'b0;
                ptr_next     = PTR_W'(ptr_red);
            end
            REQ_LOAD_CNT:
            begin
                count_next = {1'b0, req.count_value} + {16'd0, channel_mode_reg};
            end
            REQ_XFER:
            begin
                if (count_reg != '0)
                begin
                    count_next   = count_dec;
                    allowed_next = 1'b0;
                    end_next     = (count_dec == '0);
                    if (req.to_stack)
                    begin
                        ptr_next   = ptr_inc;
                        mem_cmd.wr = accept;
                    end
                end
            end
            REQ_TICK:
            begin
                if (count_reg != '0)
                begin
                    allowed_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        s1_res_next.read_data            = 8'd0;
        s1_res_next.pointer_now          = 10'(ptr_next);
        s1_res_next.transfer_allowed_out = allowed_next;
        s1_res_next.end_of_transfer_out  = end_next;
        s1_res_next.count_left           = count_next;

        rsp_next           = s1_res_reg;
        rsp_next.read_data = s1_pop_reg ? mem_rdata : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mode_reg <= 1'b0;
            ptr_reg          <= '0;
            count_reg        <= '0;
            allowed_reg      <= 1'b0;
            end_reg          <= 1'b0;
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr == ADDR_CHANNEL_MODE))
            begin
                channel_mode_reg <= pwdata[0];
            end
            if (accept)
            begin
                ptr_reg     <= ptr_next;
                count_reg   <= count_next;
                allowed_reg <= allowed_next;
                end_reg     <= end_next;
            end
            if (accept || s1_adv)
            begin
                s1_valid_reg <= accept;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pop_reg <= s1_pop_next;
            s1_res_reg <= s1_res_next;
        end
        if (s1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ptr_reg) < STACK_DEPTH)
        else $error("stack pointer beyond depth");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> !accept)
        else $error("transaction accepted during memory clear");

    a_pop_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_pop_reg && !s1_adv) |=> $stable(mem_rdata))
        else $error("popped byte lost while result waits");

    a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mem_cmd.wr, mem_cmd.rd}))
        else $error("memory read and write in one cycle");

    a_idle_xfer_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_XFER && count_reg == '0) |=> (count_reg == '0))
        else $error("transfer with zero count changed the count");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for stack_channel_dma_buffer_core: directed and random request streams under
// varied idle/stall patterns, each result checked against a model of stack, pointer, count
// and flags. Depends on scdb_pkg and the block's RTL.
module testbench;
    import scdb_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int PRINT_LIMIT = 100;
    localparam int HOLDOFF_CYCLES = 300;
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0]  stack_image [DEPTH];
    logic [9:0]  sp_image;
    logic [16:0] count_image;
    logic        allowed_image;
    logic        end_image;
    logic        mode_image;
    rsp_t        expected_rsp [$];

    int fail_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int drained_transfers = 0;
    int idle_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int holdoff_left = 0;

    stack_channel_dma_buffer_core dut (.*);

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
        begin
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        end
    endtask

    function automatic void push_image(input logic [7:0] value);
        stack_image[sp_image] = value;
        sp_image = 10'((int'(sp_image) + 1) % DEPTH);
    endfunction

    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        res = '0;
        case (r.req_type)
            REQ_PUSH:
            begin
                count_image = '0;
                allowed_image = 1'b0;
                push_image(r.data_byte);
            end
            REQ_POP:
            begin
                count_image = '0;
                allowed_image = 1'b0;
                sp_image = (sp_image == 0) ? 10'(DEPTH - 1) : sp_image - 10'd1;
                res.read_data = stack_image[sp_image];
            end
            REQ_LOAD_PTR:
            begin
                sp_image = 10'(int'(r.pointer_value) % DEPTH);
                count_image = '0;
                allowed_image = 1'b0;
            end
            REQ_LOAD_CNT:
            begin
                count_image = {1'b0, r.count_value} + 17'(mode_image);
            end
            REQ_XFER:
            begin
                if (count_image != 0)
                begin
                    count_image = count_image - 17'd1;
                    if (r.to_stack)
                    begin
                        push_image(r.data_byte);
                    end
                    allowed_image = 1'b0;
                    end_image = (count_image == 0);
                    if (end_image)
                    begin
                        drained_transfers++;
                    end
                end
            end
            REQ_TICK:
            begin
                if (count_image != 0)
                begin
                    allowed_image = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.pointer_now = sp_image;
        res.transfer_allowed_out = allowed_image;
        res.end_of_transfer_out = end_image;
        res.count_left = count_image;
        return res;
    endfunction

    function automatic req_t request_of(input logic [2:0] kind, input logic [7:0] value,
                                        input logic [9:0] ptr, input logic [15:0] cnt,
                                        input logic dir);
        req_t r;
        r.req_type = kind;
        r.data_byte = value;
        r.pointer_value = ptr;
        r.count_value = cnt;
        r.to_stack = dir;
        return r;
    endfunction

    function automatic req_t random_req(input logic [2:0] kind);
        return request_of(kind, 8'($urandom_range(255)), 10'($urandom_range(1023)),
                          16'($urandom_range(65535)), 1'($urandom_range(1)));
    endfunction

    task automatic send_req(input req_t item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        expected_rsp.push_back(apply_request(item));
        sent_count++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_CHANNEL_MODE;
        pwdata <= {31'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        mode_image = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== {31'b0, value})
        begin
            report_mismatch("channel_mode readback", prdata, value);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed();
        write_mode(1'b0);
        send_req(request_of(REQ_POP, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_PUSH, 8'hff, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_PUSH, 8'h00, 10'h3ff, 16'hffff, 1'b1));
        send_req(request_of(REQ_POP, 8'hff, 10'd0, 16'd0, 1'b1));
        send_req(request_of(REQ_POP, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_LOAD_PTR, 8'h00, 10'h3ff, 16'd0, 1'b0));
        send_req(request_of(REQ_PUSH, 8'h5a, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_LOAD_PTR, 8'hff, 10'd0, 16'hffff, 1'b1));
        send_req(request_of(REQ_XFER, 8'h77, 10'd0, 16'd0, 1'b1));
        send_req(request_of(REQ_TICK, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_LOAD_CNT, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_LOAD_CNT, 8'h00, 10'd0, 16'd2, 1'b0));
        send_req(request_of(REQ_TICK, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_XFER, 8'ha5, 10'd0, 16'd0, 1'b1));
        send_req(request_of(REQ_TICK, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_XFER, 8'h3c, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_XFER, 8'hc3, 10'd0, 16'd0, 1'b1));
        send_req(request_of(REQ_LOAD_CNT, 8'h00, 10'd0, 16'hffff, 1'b0));
        send_req(request_of(REQ_TICK, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_PUSH, 8'h3c, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_POP, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_SPARE6, 8'h12, 10'h155, 16'h5555, 1'b1));
        send_req(request_of(REQ_SPARE7, 8'hff, 10'h3ff, 16'hffff, 1'b1));
        send_req(request_of(REQ_LOAD_CNT, 8'h00, 10'd0, 16'd1, 1'b0));
        send_req(request_of(REQ_XFER, 8'h00, 10'd0, 16'd0, 1'b0));
        drain();
    endtask

    task automatic test_channel_mode();
        write_mode(1'b1);
        send_req(request_of(REQ_LOAD_CNT, 8'h00, 10'd0, 16'hffff, 1'b0));
        send_req(request_of(REQ_TICK, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_XFER, 8'h81, 10'd0, 16'd0, 1'b1));
        send_req(request_of(REQ_LOAD_CNT, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_TICK, 8'h00, 10'd0, 16'd0, 1'b0));
        send_req(request_of(REQ_XFER, 8'h18, 10'd0, 16'd0, 1'b1));
        send_req(request_of(REQ_POP, 8'h00, 10'd0, 16'd0, 1'b0));
        drain();
        write_mode(1'b0);
    endtask

    task automatic send_random_burst();
        int pick;
        int n;
        req_t item;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            item = random_req(REQ_LOAD_CNT);
            if ($urandom_range(9) != 0)
            begin
                item.count_value = 16'($urandom_range(8));
            end
            send_req(item);
            n = $urandom_range(12, 1);
            repeat (n)
            begin
                item = random_req(($urandom_range(3) == 0) ? REQ_TICK : REQ_XFER);
                if ($urandom_range(3) != 0)
                begin
                    item.to_stack = 1'b1;
                end
                send_req(item);
            end
        end
        else if (pick < 80)
        begin
            if ($urandom_range(3) == 0)
            begin
                send_req(random_req(REQ_LOAD_PTR));
            end
            n = $urandom_range(6, 1);
            repeat (n) send_req(random_req(REQ_PUSH));
            repeat ($urandom_range(n + 1)) send_req(random_req(REQ_POP));
        end
        else
        begin
            send_req(random_req(3'($urandom_range(7))));
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic mode, input int items);
        int start;
        write_mode(mode);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        start = sent_count;
        while (sent_count - start < items)
        begin
            send_random_burst();
        end
        drain();
    endtask

    task automatic test_backpressure();
        int start;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        holdoff_left = HOLDOFF_CYCLES;
        start = sent_count;
        while (sent_count - start < 150)
        begin
            send_random_burst();
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("result with nothing pending", rsp, 0);
            end
            else
            begin
                want = expected_rsp.pop_front();
                checked_count++;
                if (rsp.read_data !== want.read_data)
                    report_mismatch("read_data", rsp.read_data, want.read_data);
                if (rsp.pointer_now !== want.pointer_now)
                    report_mismatch("pointer_now", rsp.pointer_now, want.pointer_now);
                if (rsp.transfer_allowed_out !== want.transfer_allowed_out)
                    report_mismatch("transfer_allowed_out", rsp.transfer_allowed_out,
                                    want.transfer_allowed_out);
                if (rsp.end_of_transfer_out !== want.end_of_transfer_out)
                    report_mismatch("end_of_transfer_out", rsp.end_of_transfer_out,
                                    want.end_of_transfer_out);
                if (rsp.count_left !== want.count_left)
                    report_mismatch("count_left", rsp.count_left, want.count_left);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     IDLE_LIMIT, expected_rsp.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            stack_image[i] = '0;
        end
        sp_image = '0;
        count_image = '0;
        allowed_image = 1'b0;
        end_image = 1'b0;
        mode_image = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_channel_mode();
        test_random_phase(0, 0, 1'b0, 330);
        test_random_phase(71, 0, 1'b1, 330);
        test_random_phase(0, 71, 1'b0, 330);
        test_random_phase(31, 31, 1'b1, 330);
        test_backpressure();

        $display("covered %0d requests: directed corners, both channel modes, four idle/stall mixes",
                 sent_count);
        $display("and a %0d-cycle output hold-off; %0d results checked, %0d counts run to zero",
                 HOLDOFF_CYCLES, checked_count, drained_transfers);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
